// ===== hw/rtl/imp_pkg.sv =====
// Shared types, codes and field tables of the ISO 8583 message parser.
`timescale 1ns / 1ps
package imp_pkg;

  localparam int MAX_MESSAGE_BYTES = 4096;
  localparam int LEN_W             = 13;
  localparam int FIFO_DEPTH        = 4;
  localparam int FIFO_AW           = $clog2(FIFO_DEPTH);

  localparam logic [LEN_W-1:0] MAX_LEN   = LEN_W'(MAX_MESSAGE_BYTES);
  localparam logic [LEN_W-1:0] POS_LIMIT = {LEN_W{1'b1}};

  typedef enum logic [2:0] {
    PH_WAIT, PH_MTI, PH_PBMP, PH_SBMP, PH_WALK, PH_PREFIX, PH_DATA, PH_DONE
  } phase_t;

  localparam logic [2:0] CLS_MTI    = 3'd0;
  localparam logic [2:0] CLS_PBMP   = 3'd1;
  localparam logic [2:0] CLS_SBMP   = 3'd2;
  localparam logic [2:0] CLS_PREFIX = 3'd3;
  localparam logic [2:0] CLS_DATA   = 3'd4;
  localparam logic [2:0] CLS_DISC   = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_TRUNC = 2'd2;

  // One queued input byte, length already clamped
  typedef struct packed {
    logic [7:0]       byte_value;
    logic [LEN_W-1:0] eff_len;
    logic             first_byte;
  } item_t;

  typedef struct packed {
    logic [2:0] byte_class;
    logic [7:0] field_number;
    logic [7:0] data_byte;
    logic [9:0] field_offset;
    logic [9:0] field_length;
    logic       last_of_field;
    logic       end_of_message;
    logic [1:0] status;
  } result_t;

  function automatic logic [3:0] fixed_length(input logic [7:0] f);
    logic [3:0] l;
    l = 4'd0;
    unique case (f)
      8'd3:    l = 4'd6;
      8'd4:    l = 4'd12;
      8'd7:    l = 4'd10;
      8'd11:   l = 4'd6;
      8'd12:   l = 4'd6;
      8'd37:   l = 4'd12;
      8'd41:   l = 4'd8;
      8'd49:   l = 4'd3;
      default: l = 4'd0;
    endcase
    return l;
  endfunction

  function automatic logic is_prefix_field(input logic [7:0] f);
    return (f == 8'd2) || (f == 8'd102) || (f == 8'd48);
  endfunction

  function automatic logic [1:0] prefix_width(input logic [7:0] f);
    return (f == 8'd48) ? 2'd3 : 2'd2;
  endfunction

endpackage

// ===== hw/rtl/imp_front.sv =====
// Input side: accept bytes, clamp the message length, queue them for the parser.
`timescale 1ns / 1ps
module imp_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    byte_value,
  input  logic [12:0]   message_length,
  input  logic          first_byte,
  output logic          head_valid,
  output imp_pkg::item_t head,
  input  logic          pop
);
  import imp_pkg::*;

  item_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;
  logic               push;
  item_t              in_item;

  assign in_ready   = (cnt_r != (FIFO_AW+1)'(FIFO_DEPTH));
  assign push       = in_valid && in_ready;
  assign head_valid = (cnt_r != '0);
  assign head       = mem[rd_ptr_r];

  always_comb begin
    in_item.byte_value = byte_value;
    in_item.eff_len    = (message_length > MAX_LEN) ? MAX_LEN : message_length;
    in_item.first_byte = first_byte;
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/imp_back.sv =====
// Parser: tag each queued byte, scan the bitmap one field a cycle while a byte waits, register the result.
`timescale 1ns / 1ps
module imp_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  imp_pkg::item_t   head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output imp_pkg::result_t out_res
);
  import imp_pkg::*;

  phase_t           phase_r, phase_nxt;
  logic [LEN_W-1:0] pos_r, pos_nxt;
  logic [127:0]     bmp_r, bmp_nxt;
  logic [7:0]       cur_r, cur_nxt;
  logic [7:0]       walk_r, walk_nxt;
  logic [9:0]       rem_r, rem_nxt;
  logic [9:0]       acc_r, acc_nxt;
  logic [1:0]       dl_r, dl_nxt;
  logic             nd_r, nd_nxt;
  logic [1:0]       err_r, err_nxt;
  logic [9:0]       doff_r, doff_nxt;
  logic             out_valid_r, out_valid_nxt;
  result_t          out_res_r, res;
  logic             load;

  logic [LEN_W-1:0] len;
  logic             can_go;
  logic [6:0]       wb;
  logic             wbit;
  logic [7:0]       maxf;
  logic [1:0]       pw;
  logic [3:0]       fl;
  logic [2:0]       bsel;
  logic [3:0]       digit;
  logic [1:0]       cpw;

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_comb begin
    len    = head.eff_len;
    can_go = !out_valid_r || out_ready;
    wb     = 7'(walk_r - 8'd1);
    wbit   = bmp_r[{wb[6:3], ~wb[2:0]}];
    maxf   = bmp_r[7] ? 8'd128 : 8'd64;
    pw     = prefix_width(walk_r);
    fl     = fixed_length(walk_r);
    bsel   = pos_r[2:0] - 3'd4;
    digit  = 4'(head.byte_value - 8'h30);
  end

  // Next state and datapath
  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    bmp_nxt   = bmp_r;
    cur_nxt   = cur_r;
    walk_nxt  = walk_r;
    rem_nxt   = rem_r;
    acc_nxt   = acc_r;
    dl_nxt    = dl_r;
    nd_nxt    = nd_r;
    err_nxt   = err_r;
    doff_nxt  = doff_r;
    cpw       = prefix_width(cur_r);
    pop       = 1'b0;
    load      = 1'b0;
    res       = '0;

    if (head_valid) begin
      if (!head.first_byte && phase_r == PH_WALK && pos_r < len) begin
        // one bitmap field per cycle; the byte stays queued
        if (walk_r > maxf) begin
          cur_nxt   = maxf;
          phase_nxt = PH_DONE;
        end else if (wbit) begin
          cur_nxt = walk_r;
          if (is_prefix_field(walk_r)) begin
            if ({1'b0, pos_r} + 14'(pw) > {1'b0, len}) begin
              err_nxt   = ST_TRUNC;
              phase_nxt = PH_DONE;
            end else begin
              dl_nxt    = pw;
              acc_nxt   = '0;
              nd_nxt    = 1'b0;
              phase_nxt = PH_PREFIX;
            end
          end else if (fl != 4'd0 && {1'b0, pos_r} + 14'(fl) <= {1'b0, len}) begin
            rem_nxt   = 10'(fl);
            doff_nxt  = '0;
            phase_nxt = PH_DATA;
          end else begin
            walk_nxt = walk_r + 8'd1;
          end
        end else begin
          walk_nxt = walk_r + 8'd1;
        end
      end else if (can_go) begin
        pop  = 1'b1;
        load = 1'b1;
        if (head.first_byte) begin
          phase_nxt = PH_MTI;
          pos_nxt   = '0;
          bmp_nxt   = '0;
          cur_nxt   = '0;
          walk_nxt  = '0;
          rem_nxt   = '0;
          acc_nxt   = '0;
          dl_nxt    = '0;
          nd_nxt    = 1'b0;
          err_nxt   = ST_OK;
          doff_nxt  = '0;
        end
        cpw            = prefix_width(cur_nxt);
        res.byte_class = CLS_DISC;
        res.data_byte  = head.byte_value;
        if (phase_nxt != PH_WAIT) begin
          if (head.first_byte && len < LEN_W'(12)) begin
            err_nxt   = ST_SHORT;
            phase_nxt = PH_DONE;
          end
          if (pos_nxt < len) begin
            res.end_of_message = (pos_nxt + LEN_W'(1) == len);
            unique case (phase_nxt)
              PH_MTI: begin
                res.byte_class = CLS_MTI;
                if (pos_nxt >= LEN_W'(3)) phase_nxt = PH_PBMP;
              end
              PH_PBMP: begin
                res.byte_class = CLS_PBMP;
                bmp_nxt[{1'b0, bsel, 3'b000} +: 8] = head.byte_value;
                if (pos_nxt >= LEN_W'(11)) begin
                  if (bmp_nxt[7]) begin
                    if (len < LEN_W'(20)) begin
                      err_nxt   = ST_SHORT;
                      phase_nxt = PH_DONE;
                    end else begin
                      phase_nxt = PH_SBMP;
                    end
                  end else begin
                    cur_nxt   = 8'd1;
                    walk_nxt  = 8'd2;
                    phase_nxt = PH_WALK;
                  end
                end
              end
              PH_SBMP: begin
                res.byte_class = CLS_SBMP;
                bmp_nxt[{1'b1, bsel, 3'b000} +: 8] = head.byte_value;
                if (pos_nxt >= LEN_W'(19)) begin
                  cur_nxt   = 8'd1;
                  walk_nxt  = 8'd2;
                  phase_nxt = PH_WALK;
                end
              end
              PH_PREFIX: begin
                res.byte_class   = CLS_PREFIX;
                res.field_number = cur_nxt;
                res.field_offset = 10'(cpw - dl_nxt);
                if (!nd_nxt && head.byte_value >= 8'h30 && head.byte_value <= 8'h39) begin
                  acc_nxt = (acc_nxt << 3) + (acc_nxt << 1) + 10'(digit);
                end else begin
                  nd_nxt = 1'b1;
                end
                if (dl_nxt != 2'd0) dl_nxt = dl_nxt - 2'd1;
                if (dl_nxt == 2'd0) begin
                  if (acc_nxt != '0 &&
                      {1'b0, pos_nxt} + 14'd1 + 14'(acc_nxt) <= {1'b0, len}) begin
                    rem_nxt   = acc_nxt;
                    doff_nxt  = '0;
                    phase_nxt = PH_DATA;
                  end else begin
                    walk_nxt  = cur_nxt + 8'd1;
                    phase_nxt = PH_WALK;
                  end
                  acc_nxt = '0;
                  nd_nxt  = 1'b0;
                end
              end
              PH_DATA: begin
                res.byte_class   = CLS_DATA;
                res.field_number = cur_nxt;
                res.field_offset = doff_nxt;
                res.field_length = doff_nxt + rem_nxt;
                if (rem_nxt != '0) rem_nxt = rem_nxt - 10'd1;
                doff_nxt = doff_nxt + 10'd1;
                if (rem_nxt == '0) begin
                  res.last_of_field = 1'b1;
                  doff_nxt  = '0;
                  walk_nxt  = cur_nxt + 8'd1;
                  phase_nxt = PH_WALK;
                end
              end
              default: begin
                res.byte_class = CLS_DISC;
              end
            endcase
          end
          if (pos_nxt != POS_LIMIT) pos_nxt = pos_nxt + LEN_W'(1);
        end
        res.status = err_nxt;
      end
    end
  end

  // Output register hand-off
  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_WAIT;
      pos_r       <= '0;
      bmp_r       <= '0;
      cur_r       <= '0;
      walk_r      <= '0;
      rem_r       <= '0;
      acc_r       <= '0;
      dl_r        <= '0;
      nd_r        <= 1'b0;
      err_r       <= ST_OK;
      doff_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      bmp_r       <= bmp_nxt;
      cur_r       <= cur_nxt;
      walk_r      <= walk_nxt;
      rem_r       <= rem_nxt;
      acc_r       <= acc_nxt;
      dl_r        <= dl_nxt;
      nd_r        <= nd_nxt;
      err_r       <= err_nxt;
      doff_r      <= doff_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hw/rtl/iso8583_message_parser.sv =====
// Top level of the ISO 8583 message parser: input queue, parser and stream packing.
//
//  channel | dir | tdata (low bit up)                          | tuser      | tlast
//  in_     | in  | byte_value[7:0], message_length[20:8]       | first_byte | -
//  out_    | out | field_number, data_byte, field_offset,      | byte_class | end_of_message
//          |     | field_length, last_of_field, status         |            |
//
// Each byte is tagged when it is popped. In a field walk the parser first scans
// the bitmap field by field while the byte stays queued, looking for the next
// present field, the field that is taken included, and one more step when the
// scan runs past the last field. The result is registered and shows in the
// cycle after the pop. A four-entry input queue absorbs the scan cycles; the
// output register holds a result until it is taken, so a stalled output stops
// popping (a running scan goes on), and the input once the queue is full.
// Reset (rst_n low, synchronous) empties the queue and returns to waiting for
// the first byte of a message.
`timescale 1ns / 1ps
module iso8583_message_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // byte_value[7:0], message_length[20:8], zero pad
  input  logic        in_tuser,   // first_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // field_number[7:0], data_byte[15:8],
                                  // field_offset[25:16], field_length[35:26],
                                  // last_of_field[36], status[38:37], zero pad
  output logic [2:0]  out_tuser,  // byte_class
  output logic        out_tlast   // end_of_message
);
  import imp_pkg::*;

  logic    head_valid;
  item_t   head;
  logic    pop;
  result_t res;

  imp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .byte_value     (in_tdata[7:0]),
    .message_length (in_tdata[20:8]),
    .first_byte     (in_tuser),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (pop)
  );

  imp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (res)
  );

  // Pack the registered result onto the stream
  assign out_tdata = {1'b0, res.status, res.last_of_field, res.field_length,
                      res.field_offset, res.data_byte, res.field_number};
  assign out_tuser = res.byte_class;
  assign out_tlast = res.end_of_message;

endmodule

// ===== verif/tb_iso8583_message_parser.sv =====
// Self-checking testbench of the ISO 8583 message parser stream block.
`timescale 1ns / 1ps
module tb_iso8583_message_parser;
  import imp_pkg::*;

  typedef struct packed {
    logic [7:0]  byte_value;
    logic [12:0] msg_len;
    logic        first_byte;
  } in_item_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // byte_value[7:0], message_length[20:8], zero pad
  logic        in_tuser;   // first_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // field_number, data_byte, field_offset, field_length,
                           // last_of_field, status, zero pad
  logic [2:0]  out_tuser;  // byte_class
  logic        out_tlast;  // end_of_message

  iso8583_message_parser dut (.*);

  // Parser state mirror
  logic [12:0] pm_pos;
  logic [7:0]  pm_bmp [16];
  int unsigned pm_field;
  phase_t      pm_phase;
  int unsigned pm_remaining, pm_acc, pm_digits_left, pm_offset;
  logic        pm_nondigit;
  logic [1:0]  pm_err;

  in_item_t    pending_bytes[$];
  result_t     expected_tags[$];
  int unsigned errors, tags_seen, cycles;
  logic        stim_done, quiet_tail;
  int unsigned tx_gap, rx_gap, rx_hold;
  logic        in_acc;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic field_present(input int unsigned f);
    int unsigned b;
    b = (f - 1) & 127;
    return pm_bmp[b >> 3][7 - (b & 7)];
  endfunction

  function automatic int unsigned fixed_len_of(input int unsigned f);
    case (f)
      3, 11, 12: return 6;
      4, 37:     return 12;
      7:         return 10;
      41:        return 8;
      49:        return 3;
      default:   return 0;
    endcase
  endfunction

  function automatic logic has_prefix(input int unsigned f);
    return f == 2 || f == 48 || f == 102;
  endfunction

  function automatic void parser_clear();
    pm_pos = '0;
    foreach (pm_bmp[i]) pm_bmp[i] = 8'h00;
    pm_field = 0; pm_phase = PH_WAIT; pm_remaining = 0; pm_acc = 0;
    pm_digits_left = 0; pm_nondigit = 1'b0; pm_err = ST_OK; pm_offset = 0;
  endfunction

  // Find the next present field that can take the byte at pos
  function automatic void walk_next(input int unsigned pos, input int unsigned len);
    int unsigned top, fl;
    top = pm_bmp[0][7] ? 128 : 64;
    for (int unsigned i = pm_field + 1; i <= top; i++) begin
      if (!field_present(i)) continue;
      pm_field = i;
      if (has_prefix(i)) begin
        if (pos + (i == 48 ? 3 : 2) > len) begin
          pm_err = ST_TRUNC;
          pm_phase = PH_DONE;
          return;
        end
        pm_digits_left = (i == 48) ? 3 : 2;
        pm_acc = 0; pm_nondigit = 1'b0; pm_phase = PH_PREFIX;
        return;
      end
      fl = fixed_len_of(i);
      if (fl > 0 && pos + fl <= len) begin
        pm_remaining = fl; pm_offset = 0; pm_phase = PH_DATA;
        return;
      end
    end
    pm_field = top;
    pm_phase = PH_DONE;
  endfunction

  function automatic result_t tag_byte(input in_item_t it);
    result_t r;
    int unsigned pos, len, w;
    r = '0;
    r.byte_class = CLS_DISC;
    r.data_byte  = it.byte_value;
    if (it.first_byte) begin
      parser_clear();
      pm_phase = PH_MTI;
    end
    if (pm_phase != PH_WAIT) begin
      pos = pm_pos;
      len = (it.msg_len < MAX_MESSAGE_BYTES) ? it.msg_len : MAX_MESSAGE_BYTES;
      if (it.first_byte && len < 12) begin
        pm_err = ST_SHORT; pm_phase = PH_DONE;
      end
      if (pos < len) begin
        r.end_of_message = (pos + 1 == len);
        if (pm_phase == PH_WALK) walk_next(pos, len);
        case (pm_phase)
          PH_MTI: begin
            r.byte_class = CLS_MTI;
            if (pos >= 3) pm_phase = PH_PBMP;
          end
          PH_PBMP: begin
            r.byte_class = CLS_PBMP;
            pm_bmp[(pos - 4) & 7] = it.byte_value;
            if (pos >= 11) begin
              if (pm_bmp[0][7]) begin
                if (len < 20) begin
                  pm_err = ST_SHORT; pm_phase = PH_DONE;
                end else pm_phase = PH_SBMP;
              end else begin
                pm_field = 1; pm_phase = PH_WALK;
              end
            end
          end
          PH_SBMP: begin
            r.byte_class = CLS_SBMP;
            pm_bmp[8 + ((pos - 12) & 7)] = it.byte_value;
            if (pos >= 19) begin
              pm_field = 1; pm_phase = PH_WALK;
            end
          end
          PH_PREFIX: begin
            w = (pm_field == 48) ? 3 : 2;
            r.byte_class   = CLS_PREFIX;
            r.field_number = 8'(pm_field);
            r.field_offset = 10'((w - pm_digits_left) & 3);
            if (!pm_nondigit && it.byte_value >= 8'h30 && it.byte_value <= 8'h39)
              pm_acc = (pm_acc * 10 + (it.byte_value - 8'h30)) & 10'h3ff;
            else
              pm_nondigit = 1'b1;
            if (pm_digits_left > 0) pm_digits_left--;
            if (pm_digits_left == 0) begin
              if (pm_acc > 0 && pos + 1 + pm_acc <= len) begin
                pm_remaining = pm_acc; pm_offset = 0; pm_phase = PH_DATA;
              end else pm_phase = PH_WALK;
              pm_acc = 0; pm_nondigit = 1'b0;
            end
          end
          PH_DATA: begin
            r.byte_class   = CLS_DATA;
            r.field_number = 8'(pm_field);
            r.field_offset = 10'(pm_offset);
            r.field_length = 10'(pm_offset + pm_remaining);
            if (pm_remaining > 0) pm_remaining--;
            pm_offset = (pm_offset + 1) & 10'h3ff;
            if (pm_remaining == 0) begin
              r.last_of_field = 1'b1; pm_offset = 0; pm_phase = PH_WALK;
            end
          end
          default: ;
        endcase
      end
      if (pm_pos != POS_LIMIT) pm_pos++;
    end
    r.status = pm_err;
    return r;
  endfunction

  function automatic void push_byte(input logic [7:0] b, input int unsigned len,
                                    input logic first);
    in_item_t it;
    it.byte_value = b;
    it.msg_len    = 13'(len);
    it.first_byte = first;
    pending_bytes.push_back(it);
  endfunction

  function automatic logic [7:0] rnd_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Queue one message: bytes[] holds its content, len is the length reported
  function automatic void push_msg(input logic [7:0] bytes[$], input int unsigned len);
    foreach (bytes[i]) push_byte(bytes[i], len, i == 0);
  endfunction

  // Build a well-formed message with random fields; rarely malformed
  function automatic void build_msg(output logic [7:0] m[$], input logic use_sec,
                                    input int unsigned density);
    logic [7:0] bmp [16];
    int unsigned fl, v;
    m = {};
    for (int i = 0; i < 4; i++) m.push_back(8'(8'h30 + $urandom_range(0, 9)));
    foreach (bmp[i]) bmp[i] = 8'h00;
    for (int f = 2; f <= (use_sec ? 128 : 64); f++) begin
      if (has_prefix(f) || fixed_len_of(f) > 0 ? ($urandom_range(0, 99) < density)
                                                : ($urandom_range(0, 99) < 4))
        bmp[(f - 1) >> 3][7 - ((f - 1) & 7)] = 1'b1;
    end
    bmp[0][7] = use_sec;
    for (int i = 0; i < (use_sec ? 16 : 8); i++) m.push_back(bmp[i]);
    for (int f = 2; f <= (use_sec ? 128 : 64); f++) begin
      if (!bmp[(f - 1) >> 3][7 - ((f - 1) & 7)]) continue;
      if (has_prefix(f)) begin
        v = $urandom_range(0, 12);
        if (f == 48) m.push_back(8'h30);
        m.push_back(8'(8'h30 + v / 10));
        m.push_back(8'(8'h30 + v % 10));
        if ($urandom_range(0, 15) == 0) m[m.size() - 1] = rnd_byte();
        fl = v;
      end else fl = fixed_len_of(f);
      for (int k = 0; k < fl; k++) m.push_back(rnd_byte());
    end
  endfunction

  // Record whether the offered input was taken at this edge
  always @(posedge clk) begin
    in_acc <= in_tvalid && in_tready;
  end

  // Driver: offer pending bytes with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_acc) begin
      // hold the offered transfer
    end else begin
      if (tx_gap > 0) tx_gap = tx_gap - 1;
      else if (!quiet_tail && $urandom_range(0, 15) == 0) tx_gap = $urandom_range(1, 11);
      if (tx_gap == 0 && pending_bytes.size() > 0) begin
        in_item_t it;
        it = pending_bytes.pop_front();
        expected_tags.push_back(tag_byte(it));
        in_tdata  <= {3'b0, it.msg_len, it.byte_value};
        in_tuser  <= it.first_byte;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver backpressure: random bursts plus one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold = rx_hold - 1;
      out_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap = rx_gap - 1;
      out_tready <= 1'b0;
    end else begin
      if (!quiet_tail && $urandom_range(0, 11) == 0) rx_gap = $urandom_range(1, 11);
      out_tready <= (rx_gap == 0);
    end
  end

  // Monitor: compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      result_t got, want;
      got = '0;
      got.byte_class     = out_tuser;
      got.end_of_message = out_tlast;
      got.field_number   = out_tdata[7:0];
      got.data_byte      = out_tdata[15:8];
      got.field_offset   = out_tdata[25:16];
      got.field_length   = out_tdata[35:26];
      got.last_of_field  = out_tdata[36];
      got.status         = out_tdata[38:37];
      tags_seen = tags_seen + 1;
      if (expected_tags.size() == 0) begin
        errors = errors + 1;
        $display("%0t: unexpected result %h", $time, got);
      end else begin
        want = expected_tags.pop_front();
        if (got != want || out_tdata[39] !== 1'b0) begin
          errors = errors + 1;
          $display("%0t: mismatch expected cls=%0d fld=%0d byte=%h off=%0d len=%0d last=%0d eom=%0d st=%0d",
                   $time, want.byte_class, want.field_number, want.data_byte,
                   want.field_offset, want.field_length, want.last_of_field,
                   want.end_of_message, want.status);
          $display("%0t:          actual   cls=%0d fld=%0d byte=%h off=%0d len=%0d last=%0d eom=%0d st=%0d",
                   $time, got.byte_class, got.field_number, got.data_byte,
                   got.field_offset, got.field_length, got.last_of_field,
                   got.end_of_message, got.status);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles > 400000) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles,
               expected_tags.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    logic [7:0] m[$];
    int unsigned len;
    errors = 0; tags_seen = 0; cycles = 0; stim_done = 1'b0; quiet_tail = 1'b0;
    tx_gap = 0; rx_gap = 0; rx_hold = 0;
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0; in_tuser = 1'b0; out_tready = 1'b0;
    parser_clear();

    // Bytes before any message start, then a too-short message with length 1
    push_byte(8'hff, 8191, 1'b0);
    push_byte(8'h00, 1, 1'b0);
    push_msg('{8'h30, 8'h31}, 1);
    // Primary bitmap with fields 2 (prefix), 3, 4 and an unknown field 5
    push_msg('{8'h30, 8'h32, 8'h30, 8'h30, 8'h78, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
               8'h00, 8'h00, 8'h30, 8'h32, 8'hab, 8'hcd}, 16);
    // Secondary bit set but length under 20; length clamped beyond maximum
    push_msg('{8'h30, 8'h30, 8'h30, 8'h30, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00,
               8'h00, 8'h00, 8'h00, 8'hff, 8'hff}, 14);
    push_msg('{8'h31, 8'h31, 8'h31, 8'h31, 8'h40, 8'h00, 8'h00, 8'h00, 8'h00,
               8'h00, 8'h00, 8'h00, 8'h39, 8'h00}, 8191);
    // Field 2 prefix that does not fit in the message
    push_msg('{8'h30, 8'h30, 8'h30, 8'h30, 8'h40, 8'h00, 8'h00, 8'h00, 8'h00,
               8'h00, 8'h00, 8'h00, 8'h35}, 13);

    repeat (6) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    // Hold off the receiver long enough to fill the queue and stall the input
    rx_hold = 300;

    // Random messages: mostly well-formed, some noise and wrong lengths
    while (pending_bytes.size() + expected_tags.size() + tags_seen < 1950) begin
      build_msg(m, 1'($urandom_range(0, 1)), $urandom_range(10, 70));
      len = m.size();
      case ($urandom_range(0, 9))
        0: len = $urandom_range(1, len + 5);
        1: len = len + $urandom_range(1, 4);
        2: len = (len > 6) ? len - $urandom_range(1, 6) : len;
        3: for (int k = 0; k < m.size(); k++) m[k] = rnd_byte();
        4: if ($urandom_range(0, 3) == 0) len = 8191 - $urandom_range(0, 4095);
        default: ;
      endcase
      if ($urandom_range(0, 15) == 0) m.push_back(rnd_byte());
      if ($urandom_range(0, 19) == 0) m = m[0:$urandom_range(0, m.size() - 1)];
      push_msg(m, len);
      wait (pending_bytes.size() < 64);
      if (pending_bytes.size() + tags_seen > 1700) quiet_tail = 1'b1;
    end
    quiet_tail = 1'b1;
    wait (pending_bytes.size() == 0 && expected_tags.size() == 0);
    repeat (200) @(posedge clk);
    $display("Checked %0d byte tags over MTI, bitmaps, prefixed and fixed fields,", tags_seen);
    $display("short, truncated and over-long messages, with stalls on both sides.");
    if (errors == 0 && expected_tags.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
